// ===== design/shpf_pkg.sv =====
// Shared types and constants for the sync header packet framer.
package shpf_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    // Item kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_MESSAGE_ID     = 2'd0;
    localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd1;

    // Header byte positions.
    localparam logic [1:0] HDR_SYNC0  = 2'd0;
    localparam logic [1:0] HDR_SYNC1  = 2'd1;
    localparam logic [1:0] HDR_ID     = 2'd2;
    localparam logic [1:0] HDR_LENGTH = 2'd3;

    localparam logic [7:0] PAYLOAD_LENGTH_RESET = 8'd40;

    // Framer state seen by the byte generator.
    typedef struct packed {
        logic       header_sent;
        logic [7:0] running_sum;
        logic [1:0] phase;
    } frame_state_t;

    // One produced byte plus the state that follows it.
    typedef struct packed {
        logic [7:0]   out_byte;
        logic         is_checksum;
        logic         end_of_run;
        frame_state_t state_next;
    } byte_step_t;

endpackage

// ===== design/shpf_byte_gen.sv =====
// Combinational byte generator: picks the next framed byte and the following state.
module shpf_byte_gen (
    input  logic                  kind,
    input  logic [7:0]            data_byte,
    input  logic [7:0]            message_id,
    input  logic [7:0]            payload_length,
    input  shpf_pkg::frame_state_t state,
    output shpf_pkg::byte_step_t   step
);

    logic [7:0] len_byte;

    assign len_byte = payload_length + 8'd1;

    always_comb begin
        step = '0;
        step.state_next = state;
        if (!state.header_sent) begin
            // Header bytes go out one per cycle, while the output register takes them, before the item's own byte.
            unique case (state.phase)
                shpf_pkg::HDR_SYNC0:  step.out_byte = shpf_pkg::SYNC_BYTE;
                shpf_pkg::HDR_SYNC1:  step.out_byte = shpf_pkg::SYNC_BYTE;
                shpf_pkg::HDR_ID:     step.out_byte = message_id;
                shpf_pkg::HDR_LENGTH: step.out_byte = len_byte;
                default:              step.out_byte = shpf_pkg::SYNC_BYTE;
            endcase
            step.state_next.phase = state.phase + 2'd1;
            if (state.phase == shpf_pkg::HDR_LENGTH) begin
                step.state_next.header_sent = 1'b1;
                step.state_next.running_sum = message_id + len_byte;
            end
        end else if (kind == shpf_pkg::KIND_PAYLOAD) begin
            step.out_byte               = data_byte;
            step.end_of_run             = 1'b1;
            step.state_next.running_sum = state.running_sum + data_byte;
            step.state_next.phase       = shpf_pkg::HDR_SYNC0;
        end else begin
            step.out_byte               = ~state.running_sum;
            step.is_checksum            = 1'b1;
            step.end_of_run             = 1'b1;
            step.state_next.header_sent = 1'b0;
            step.state_next.running_sum = 8'd0;
            step.state_next.phase       = shpf_pkg::HDR_SYNC0;
        end
    end

endmodule

// ===== design/sync_header_packet_framer.sv =====
// Top level of the sync header packet framer: input hold stage, byte generator, output register.
// An accepted item goes into the hold stage; its bytes then leave through the output register.
// Throughput: one item per cycle inside an open packet while m_ready stays high; the first item
// of a packet also needs the four header bytes, which leave with its own byte through one output register.
// The header bytes leave one byte per cycle, while m_ready stays high, through the single byte-wide output register.
// Reset (aresetn low, synchronous) closes any open packet, empties both stages, clears the
// running sum and loads message_id with 0 and payload_length with 40.
module sync_header_packet_framer (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration write port.
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wr_data,
    // Input items.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_data_byte,
    // Framed bytes.
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_checksum,
    output logic       m_end_of_run
);

    // Configuration registers.
    logic [7:0] message_id_reg;
    logic [7:0] payload_length_reg;

    // Hold stage: the item currently being expanded into bytes.
    logic       hold_valid_reg;
    logic       hold_kind_reg;
    logic [7:0] hold_data_reg;

    // Packet state: whether the header is out, the running sum and the header position.
    shpf_pkg::frame_state_t state_reg;

    // Output register.
    logic       m_valid_reg;
    logic [7:0] m_out_byte_reg;
    logic       m_is_checksum_reg;
    logic       m_end_of_run_reg;

    shpf_pkg::byte_step_t step;
    logic                 produce;
    logic                 accept;

    shpf_byte_gen u_byte_gen (
        .kind           (hold_kind_reg),
        .data_byte      (hold_data_reg),
        .message_id     (message_id_reg),
        .payload_length (payload_length_reg),
        .state          (state_reg),
        .step           (step)
    );

    // A byte is produced whenever an item is held and the output register is free or
    // being emptied this cycle. The hold stage frees up on the item's last byte, so a
    // new item can come in during the same cycle.
    assign produce = hold_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !hold_valid_reg || (produce && step.end_of_run);
    assign accept  = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_is_checksum = m_is_checksum_reg;
    assign m_end_of_run  = m_end_of_run_reg;

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            message_id_reg     <= 8'd0;
            payload_length_reg <= shpf_pkg::PAYLOAD_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                shpf_pkg::REG_MESSAGE_ID:     message_id_reg     <= cfg_wr_data;
                shpf_pkg::REG_PAYLOAD_LENGTH: payload_length_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Hold stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (accept) begin
            hold_valid_reg <= 1'b1;
        end else if (produce && step.end_of_run) begin
            hold_valid_reg <= 1'b0;
        end
    end

    // Hold stage payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_kind_reg <= s_kind;
            hold_data_reg <= s_data_byte;
        end
    end

    // Packet state advances with every produced byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (produce) begin
            state_reg <= step.state_next;
        end
    end

    // Output register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (produce) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (produce) begin
            m_out_byte_reg    <= step.out_byte;
            m_is_checksum_reg <= step.is_checksum;
            m_end_of_run_reg  <= step.end_of_run;
        end
    end

    // A checksum byte is always the last byte of its item.
    a_checksum_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_is_checksum_reg) |-> m_end_of_run_reg)
        else $error("checksum byte without end of run");

    // A header byte in the output register means its item is still held.
    a_header_keeps_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_end_of_run_reg) |-> hold_valid_reg)
        else $error("header byte out but no item held");

    // The header position only moves while the header is still going out.
    a_phase_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase != shpf_pkg::HDR_SYNC0) |-> !state_reg.header_sent)
        else $error("header position set after header finished");

    // When the header completes, the byte just loaded is the length byte.
    a_header_ends_on_length: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.header_sent) |->
            (m_out_byte_reg == payload_length_reg + 8'd1) && !m_end_of_run_reg)
        else $error("header closed on a byte other than the length");

endmodule
